>>> sv/bpst_pkg.sv
// shared types and codes of the breakpoint and single-step trigger unit
package bpst_pkg;

    // default number of breakpoint table entries
    localparam int BP_SLOTS_DEF = 16;

    // field widths of one transaction
    localparam int FUNC_W   = 4;
    localparam int SOURCE_W = 16;
    localparam int LINE_W   = 20;
    localparam int DEPTH_W  = 10;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_EVENT     = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_BP    = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_BP  = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_OVER      = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_INTO      = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_OUT       = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_CONTINUE  = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE     = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // stop reasons
    localparam logic REASON_BP   = 1'b0;
    localparam logic REASON_STEP = 1'b1;

    // execution mode
    typedef enum logic [2:0] {
        MODE_RUN   = 3'd0,
        MODE_PAUSE = 3'd1,
        MODE_OVER  = 3'd2,
        MODE_INTO  = 3'd3,
        MODE_OUT   = 3'd4
    } mode_t;

    // input transaction
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SOURCE_W-1:0] src_id;
        logic [LINE_W-1:0]   line;
        logic [DEPTH_W-1:0]  depth;
        logic [SLOT_W-1:0]   slot;
    } in_t;

    // result transaction
    typedef struct packed {
        logic                stop;
        logic                stop_reason;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   assigned_slot;
        logic                halted;
    } out_t;

    // command to the breakpoint table
    typedef struct packed {
        logic                set_en;
        logic                clr_en;
        logic                clr_all;
        logic [SOURCE_W-1:0] src_id;
        logic [LINE_W-1:0]   line;
        logic [SLOT_W-1:0]   slot;
    } tbl_cmd_t;

    // lookup and status from the breakpoint table
    typedef struct packed {
        logic              hit;
        logic              full;
        logic              bad_id;
        logic [SLOT_W-1:0] assigned;
    } tbl_stat_t;

endpackage

>>> sv/bpst_table.sv
// breakpoint table: entry storage, parallel match, slot allocation and clearing
module bpst_table #(
    parameter int BP_SLOTS = bpst_pkg::BP_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpst_pkg::tbl_cmd_t  cmd,
    output bpst_pkg::tbl_stat_t stat
);
    import bpst_pkg::*;

    localparam int IDX_W = (BP_SLOTS > 1) ? $clog2(BP_SLOTS) : 1;
    localparam int CNT_W = $clog2(BP_SLOTS + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    logic [SOURCE_W-1:0] bp_source_reg [BP_SLOTS];
    logic [LINE_W-1:0]   bp_line_reg   [BP_SLOTS];
    logic [BP_SLOTS-1:0] bp_active_reg;
    logic [CNT_W-1:0]    bp_used_reg;

    logic [BP_SLOTS-1:0] hit_vec;
    logic [BP_SLOTS-1:0] free_vec;
    logic [BP_SLOTS-1:0] free_onehot;
    logic [BP_SLOTS-1:0] append_vec;
    logic [BP_SLOTS-1:0] sel_vec;
    logic [IDX_W-1:0]    wr_idx;
    logic                any_free;
    logic                table_full;
    logic                set_do;
    logic                clr_do;

    // per-entry compare, free and append selects
    always_comb begin
        for (int i = 0; i < BP_SLOTS; i++) begin
            hit_vec[i]    = bp_active_reg[i] && (bp_source_reg[i] == cmd.src_id)
                            && (bp_line_reg[i] == cmd.line);
            free_vec[i]   = !bp_active_reg[i] && (CNT_W'(i) < bp_used_reg);
            append_vec[i] = (CNT_W'(i) == bp_used_reg);
        end
    end

    // lowest free entry wins, else append past the used count
    always_comb begin
        free_onehot = free_vec & (~free_vec + BP_SLOTS'(1));
        any_free    = |free_vec;
        table_full  = (bp_used_reg == CNT_W'(BP_SLOTS));
        sel_vec     = any_free ? free_onehot : append_vec;
        wr_idx      = '0;
        for (int i = 0; i < BP_SLOTS; i++) begin
            if (sel_vec[i]) begin
                wr_idx = wr_idx | IDX_W'(i);
            end
        end
    end

    // status toward the control logic
    always_comb begin
        stat.hit      = |hit_vec;
        stat.full     = !any_free && table_full;
        stat.bad_id   = (CMP_W'(cmd.slot) >= CMP_W'(bp_used_reg));
        stat.assigned = SLOT_W'(wr_idx);
        set_do        = cmd.set_en && !stat.full;
        clr_do        = cmd.clr_en && !stat.bad_id;
    end

    // active bits and used count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_active_reg <= '0;
            bp_used_reg   <= '0;
        end else begin
            if (cmd.clr_all) begin
                bp_active_reg <= '0;
            end else begin
                for (int i = 0; i < BP_SLOTS; i++) begin
                    if (set_do && sel_vec[i]) begin
                        bp_active_reg[i] <= 1'b1;
                    end else if (clr_do && (CMP_W'(cmd.slot) == CMP_W'(i))) begin
                        bp_active_reg[i] <= 1'b0;
                    end
                end
            end
            if (set_do && !any_free) begin
                bp_used_reg <= bp_used_reg + CNT_W'(1);
            end
        end
    end

    // entry location storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BP_SLOTS; i++) begin
            if (set_do && sel_vec[i]) begin
                bp_source_reg[i] <= cmd.src_id;
                bp_line_reg[i]   <= cmd.line;
            end
        end
    end

endmodule

>>> sv/breakpoint_step_trigger.sv
// top level of the breakpoint and single-step trigger unit
//
// Each input transaction on s_data is one command or one execute event; each
// produces exactly one result transaction on m_data, in order. Commands set a
// breakpoint (lowest inactive used entry, else a new one; status reports a full
// table), clear one entry (status reports an id >= the used count), clear all,
// start a step over, into or out at the given location and depth, continue, or
// pause. An event reports stop, the stop reason and the halted flag.
// The transaction is taken into an input register; once the output register is
// free or read, its result lands there with the table and mode state updated.
// Throughput is one transaction per cycle when unstalled, set by the single
// pass from the input register through the parallel compare of all entries.
// When m_ready is low the result waits in the output register, the next
// transaction waits in the input register, and s_ready drops once both are full.
// Reset empties both registers, clears all active bits and the used count, and
// returns to run mode with the halted flag low.
module breakpoint_step_trigger #(
    parameter int BP_SLOTS = bpst_pkg::BP_SLOTS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bpst_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bpst_pkg::out_t m_data
);
    import bpst_pkg::*;

    in_t                 in_reg;
    logic                in_valid_reg;
    out_t                out_reg;
    out_t                out_next;
    logic                out_valid_reg;
    logic                advance;

    mode_t               mode_reg;
    mode_t               mode_next;
    logic [DEPTH_W-1:0]  step_depth_reg;
    logic [LINE_W-1:0]   step_line_reg;
    logic [SOURCE_W-1:0] step_source_reg;
    logic                capture;
    logic                paused_reg;
    logic                paused_next;

    tbl_cmd_t            tbl_cmd;
    tbl_stat_t           tbl_stat;

    logic                moved;
    logic                mode_stop;
    logic                stop;

    // handshake: move the held transaction whenever the result slot frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // breakpoint table commands, committed only when the transaction moves
    always_comb begin
        tbl_cmd.set_en    = advance && (in_reg.func == FUNC_SET_BP);
        tbl_cmd.clr_en    = advance && (in_reg.func == FUNC_CLEAR_BP);
        tbl_cmd.clr_all   = advance && (in_reg.func == FUNC_CLEAR_ALL);
        tbl_cmd.src_id    = in_reg.src_id;
        tbl_cmd.line      = in_reg.line;
        tbl_cmd.slot      = in_reg.slot;
    end

    bpst_table #(
        .BP_SLOTS (BP_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tbl_cmd),
        .stat    (tbl_stat)
    );

    // stop decision for an execute event
    always_comb begin
        moved = (in_reg.src_id != step_source_reg) || (in_reg.line != step_line_reg);
        unique case (mode_reg)
            MODE_PAUSE: mode_stop = 1'b1;
            MODE_INTO:  mode_stop = moved;
            MODE_OVER:  mode_stop = (in_reg.depth <= step_depth_reg) && moved;
            MODE_OUT:   mode_stop = (in_reg.depth < step_depth_reg);
            default:    mode_stop = 1'b0;
        endcase
        stop = mode_stop || tbl_stat.hit;
    end

    // result fields and next mode state
    always_comb begin
        out_next               = '0;
        mode_next              = mode_reg;
        paused_next            = paused_reg;
        capture                = 1'b0;
        unique case (in_reg.func)
            FUNC_EVENT: begin
                out_next.stop = stop;
                if (stop) begin
                    out_next.stop_reason = (mode_reg == MODE_RUN) ? REASON_BP : REASON_STEP;
                    paused_next          = 1'b1;
                end
            end
            FUNC_SET_BP: begin
                if (tbl_stat.full) begin
                    out_next.status = STATUS_FULL;
                end else begin
                    out_next.assigned_slot = tbl_stat.assigned;
                end
            end
            FUNC_CLEAR_BP: begin
                if (tbl_stat.bad_id) begin
                    out_next.status = STATUS_BAD_ID;
                end
            end
            FUNC_OVER: begin
                mode_next   = MODE_OVER;
                capture     = 1'b1;
                paused_next = 1'b0;
            end
            FUNC_INTO: begin
                mode_next   = MODE_INTO;
                capture     = 1'b1;
                paused_next = 1'b0;
            end
            FUNC_OUT: begin
                mode_next   = MODE_OUT;
                capture     = 1'b1;
                paused_next = 1'b0;
            end
            FUNC_CONTINUE: begin
                mode_next   = MODE_RUN;
                paused_next = 1'b0;
            end
            FUNC_PAUSE: begin
                mode_next = MODE_PAUSE;
            end
            default: begin
            end
        endcase
        out_next.halted = paused_next;
    end

    // input and output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_RUN;
            paused_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                paused_reg    <= paused_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // step capture registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_depth_reg  <= '0;
            step_line_reg   <= '0;
            step_source_reg <= '0;
        end else if (advance && capture) begin
            step_depth_reg  <= in_reg.depth;
            step_line_reg   <= in_reg.line;
            step_source_reg <= in_reg.src_id;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule
